// File: rtl/nesterov_momentum_update_macros.svh
// Assertion macros used by the RTL top level of the momentum update block.
`ifndef NESTEROV_MOMENTUM_UPDATE_MACROS_SVH
`define NESTEROV_MOMENTUM_UPDATE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk_i, off while rst_ni is low.
`define NMU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nmu assertion failed");
// Checked on every rising edge of clk_i, reset included.
`define NMU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("nmu assertion failed");
`else
`define NMU_ASSERT(lbl, prop)
`define NMU_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/nmu_pkg.sv
// Types, constants and fixed-point helpers of the momentum update block.
package nmu_pkg;

  // Field widths.
  localparam int unsigned IdxW  = 12;
  localparam int unsigned DataW = 32;
  localparam int unsigned CoefW = 16;
  // Q0.16 x Q16.16 product, sum of two products, rounded sum, difference.
  localparam int unsigned ProdW = DataW + CoefW + 1;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned RndW  = SumW - CoefW;
  localparam int unsigned DiffW = RndW + 1;

  // Default velocity store depth.
  localparam int unsigned DefVelDepth = 4096;

  // Configuration register reset values.
  localparam logic [CoefW-1:0] LrReset  = 16'd655;
  localparam logic [CoefW-1:0] MomReset = 16'd58982;

  // Register indexes on the configuration port.
  localparam logic RegLearningRate = 1'b0;
  localparam logic RegMomentum     = 1'b1;

  // Item entering the velocity update stage.
  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic                    in_range;
    logic signed [DataW-1:0] v_mem;
    logic signed [ProdW-1:0] lg;
  } vel_req_t;

  // Item handed to the weight pipeline.
  typedef struct packed {
    logic signed [DataW-1:0] w;
    logic signed [ProdW-1:0] lg;
    logic signed [DataW-1:0] vn;
    logic                    vflag;
  } wt_req_t;

  // Saturated value with its clip flag.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    flag;
  } sat_t;

  // Round a Q18.32 sum to Q18.16, half up.
  function automatic logic signed [RndW-1:0] round_q(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] b;
    b = s + SumW'(32768);
    return b[SumW-1:CoefW];
  endfunction

  // Saturate to signed 32 bits and flag a clip.
  function automatic sat_t sat_q(input logic signed [DiffW-1:0] x);
    sat_t r;
    if (x[DiffW-1:DataW-1] != {(DiffW-DataW+1){x[DiffW-1]}}) begin
      r.flag  = 1'b1;
      r.value = x[DiffW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r.flag  = 1'b0;
      r.value = x[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/nesterov_momentum_update.sv
// Top level of the Nesterov momentum SGD update block.
//
//   channel  direction  handshake                      payload
//   in       input      in_valid_i / in_stall_o        element_index_i, weight_in_i, grad_in_i
//   out      output     out_valid_o / out_stall_i      weight_out_o, saturated_o
//   cfg      input      psel/penable/pwrite, pready     paddr, pwdata, prdata
//
// One beat per cycle is taken while no clearing pass runs and out_stall_i is low; a
// result passes the read, update, c, d, e and output registers. The velocity
// read-modify-write closes in one stage, and consecutive beats to the same element get
// the new velocity through a two-entry forwarding history. After reset a clearing pass
// zeroes every store entry, one entry a cycle; in_stall_o stays high until it ends.
// out_stall_i holds a stage only while that stage and every stage after it are full.
module nesterov_momentum_update #(
  parameter int unsigned VelDepth = nmu_pkg::DefVelDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [nmu_pkg::IdxW-1:0]          element_index_i,
  input  logic signed [nmu_pkg::DataW-1:0]  weight_in_i,
  input  logic signed [nmu_pkg::DataW-1:0]  grad_in_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [nmu_pkg::DataW-1:0]  weight_out_o,
  output logic                              saturated_o,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  `include "nesterov_momentum_update_macros.svh"

  localparam int unsigned AddrW = (VelDepth > 1) ? $clog2(VelDepth) : 1;
  localparam int unsigned ExtW  = AddrW + nmu_pkg::IdxW;

  // Configuration registers.
  logic [nmu_pkg::CoefW-1:0] lr_q, beta_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= nmu_pkg::LrReset;
      beta_q <= nmu_pkg::MomReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        nmu_pkg::RegLearningRate: lr_q   <= pwdata[nmu_pkg::CoefW-1:0];
        nmu_pkg::RegMomentum:     beta_q <= pwdata[nmu_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nmu_pkg::RegLearningRate: prdata = 32'(lr_q);
      nmu_pkg::RegMomentum:     prdata = 32'(beta_q);
      default:                  prdata = '0;
    endcase
  end

  // Clearing pass after reset.
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AddrW'(VelDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Pipeline control for the read and update stages.
  logic en_a, en_b, wt_stall, accept, xfer_b;
  logic a_valid_q, b_valid_q;

  assign en_b       = !b_valid_q || !wt_stall;
  assign en_a       = !a_valid_q || en_b;
  assign in_stall_o = clr_busy_q || !en_a;
  assign accept     = in_valid_i && !in_stall_o;
  assign xfer_b     = b_valid_q && !wt_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (en_a) a_valid_q <= accept;
      if (en_b) b_valid_q <= a_valid_q;
    end
  end

  // Read stage: store address and range check.
  logic [ExtW-1:0]                   in_ext;
  logic [AddrW-1:0]                  in_addr;
  logic                              in_inside;
  logic [nmu_pkg::IdxW-1:0]          a_idx_q;
  logic [AddrW-1:0]                  a_addr_q, b_addr_q;
  logic                              a_inside_q;
  logic signed [nmu_pkg::DataW-1:0]  a_w_q, a_grad_q, b_w_q;
  logic signed [nmu_pkg::ProdW-1:0]  a_lg;
  logic [nmu_pkg::DataW-1:0]         ram_rdata;
  nmu_pkg::vel_req_t                 b_q;

  assign in_ext    = ExtW'(element_index_i);
  assign in_addr   = in_ext[AddrW-1:0];
  assign in_inside = 32'(element_index_i) < 32'(VelDepth);
  assign a_lg      = $signed({1'b0, lr_q}) * a_grad_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_idx_q    <= element_index_i;
      a_addr_q   <= in_addr;
      a_inside_q <= in_inside;
      a_w_q      <= weight_in_i;
      a_grad_q   <= grad_in_i;
    end
    if (en_b && a_valid_q) begin
      b_q.idx      <= a_idx_q;
      b_q.in_range <= a_inside_q;
      b_q.v_mem    <= ram_rdata;
      b_q.lg       <= a_lg;
      b_addr_q     <= a_addr_q;
      b_w_q        <= a_w_q;
    end
  end

  // Velocity update stage and store write-back.
  logic signed [nmu_pkg::DataW-1:0] vn;
  logic                             vflag;
  logic                             ram_we;
  logic [AddrW-1:0]                 ram_waddr;
  logic [nmu_pkg::DataW-1:0]        ram_wdata;
  nmu_pkg::wt_req_t                 wt_req;

  nmu_vel_unit u_vel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (b_q),
    .beta_i   (beta_q),
    .commit_i (xfer_b),
    .vn_o     (vn),
    .vflag_o  (vflag)
  );

  assign ram_we    = clr_busy_q || (xfer_b && b_q.in_range);
  assign ram_waddr = clr_busy_q ? clr_cnt_q : b_addr_q;
  assign ram_wdata = clr_busy_q ? '0 : vn;

  nmu_vel_ram #(
    .Depth (VelDepth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Weight pipeline and output register.
  assign wt_req.w     = b_w_q;
  assign wt_req.lg    = b_q.lg;
  assign wt_req.vn    = vn;
  assign wt_req.vflag = vflag;

  nmu_wt_unit u_wt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (b_valid_q),
    .req_stall_o  (wt_stall),
    .req_i        (wt_req),
    .beta_i       (beta_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .weight_out_o (weight_out_o),
    .saturated_o  (saturated_o)
  );

  // The clearing pass never overlaps beats in flight.
  `NMU_ASSERT(a_clear_no_items, clr_busy_q |-> (!a_valid_q && !b_valid_q))
  // An accepted beat is in the read stage on the next cycle.
  `NMU_ASSERT(a_accept_to_read, accept |=> a_valid_q)
  // A held read stage keeps its beat.
  `NMU_ASSERT(a_read_hold, (a_valid_q && !en_a) |=> (a_valid_q && $stable(a_idx_q)))
  // The clearing pass ends only after the last entry.
  `NMU_ASSERT(a_clear_full, $fell(clr_busy_q) |-> ($past(clr_cnt_q) == AddrW'(VelDepth - 1)))

endmodule

// File: rtl/nmu_vel_ram.sv
// Velocity store: one write port, one registered read port.
module nmu_vel_ram #(
  parameter int unsigned Depth = nmu_pkg::DefVelDepth,
  parameter int unsigned AddrW = 12
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [nmu_pkg::DataW-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [nmu_pkg::DataW-1:0]  rdata_o
);

  logic [nmu_pkg::DataW-1:0] mem [Depth];
  logic [nmu_pkg::DataW-1:0] rdata_q;

  // Read returns the contents before a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/nmu_vel_unit.sv
// Velocity update with forwarding of the two most recent stores.
module nmu_vel_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nmu_pkg::vel_req_t                 req_i,
  input  logic [nmu_pkg::CoefW-1:0]         beta_i,
  input  logic                              commit_i,
  output logic signed [nmu_pkg::DataW-1:0]  vn_o,
  output logic                              vflag_o
);

  // Last two committed stores, newest in slot 0.
  logic                              h0_valid_q, h1_valid_q;
  logic [nmu_pkg::IdxW-1:0]          h0_idx_q, h1_idx_q;
  logic signed [nmu_pkg::DataW-1:0]  h0_val_q, h1_val_q;

  logic signed [nmu_pkg::DataW-1:0]  v;
  logic signed [nmu_pkg::ProdW-1:0]  prod;
  logic signed [nmu_pkg::SumW-1:0]   sum;
  logic signed [nmu_pkg::RndW-1:0]   rnd;
  nmu_pkg::sat_t                     vsat;
  logic                              store;

  // Old velocity: zero beyond the store, else the newest copy.
  always_comb begin
    if (!req_i.in_range) begin
      v = '0;
    end else if (h0_valid_q && (h0_idx_q == req_i.idx)) begin
      v = h0_val_q;
    end else if (h1_valid_q && (h1_idx_q == req_i.idx)) begin
      v = h1_val_q;
    end else begin
      v = req_i.v_mem;
    end
  end

  // New velocity: beta*v + lr*g, rounded and saturated.
  always_comb begin
    prod = $signed({1'b0, beta_i}) * v;
    sum  = prod + req_i.lg;
    rnd  = nmu_pkg::round_q(sum);
    vsat = nmu_pkg::sat_q(nmu_pkg::DiffW'(rnd));
  end

  assign vn_o    = vsat.value;
  assign vflag_o = vsat.flag;
  assign store   = commit_i && req_i.in_range;

  // Forwarding history, shifted on each store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_valid_q <= 1'b0;
      h1_valid_q <= 1'b0;
    end else if (store) begin
      h0_valid_q <= 1'b1;
      h1_valid_q <= h0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      h0_idx_q <= req_i.idx;
      h0_val_q <= vsat.value;
      h1_idx_q <= h0_idx_q;
      h1_val_q <= h0_val_q;
    end
  end

endmodule

// File: rtl/nmu_wt_unit.sv
// Weight pipeline: beta*v', rounding, subtraction and output register.
module nmu_wt_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_stall_o,
  input  nmu_pkg::wt_req_t                  req_i,
  input  logic [nmu_pkg::CoefW-1:0]         beta_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [nmu_pkg::DataW-1:0]  weight_out_o,
  output logic                              saturated_o
);

  logic en_c, en_d, en_e, en_o;
  logic c_valid_q, d_valid_q, e_valid_q, o_valid_q;

  nmu_pkg::wt_req_t                  c_q;
  logic signed [nmu_pkg::ProdW-1:0]  d_p_q, d_lg_q;
  logic signed [nmu_pkg::DataW-1:0]  d_w_q, e_w_q, o_w_q;
  logic                              d_flag_q, e_flag_q, o_flag_q;
  logic signed [nmu_pkg::RndW-1:0]   e_t_q;

  logic signed [nmu_pkg::ProdW-1:0]  p2;
  logic signed [nmu_pkg::SumW-1:0]   sum;
  logic signed [nmu_pkg::DiffW-1:0]  diff;
  nmu_pkg::sat_t                     wsat;

  // A stage moves when it is empty or the next one moves.
  assign en_o = !o_valid_q || !out_stall_i;
  assign en_e = !e_valid_q || en_o;
  assign en_d = !d_valid_q || en_e;
  assign en_c = !c_valid_q || en_d;
  assign req_stall_o = !en_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (en_c) c_valid_q <= req_valid_i;
      if (en_d) d_valid_q <= c_valid_q;
      if (en_e) e_valid_q <= d_valid_q;
      if (en_o) o_valid_q <= e_valid_q;
    end
  end

  // Datapath arithmetic per stage.
  always_comb begin
    p2   = $signed({1'b0, beta_i}) * c_q.vn;
    sum  = d_p_q + d_lg_q;
    diff = nmu_pkg::DiffW'(e_w_q) - nmu_pkg::DiffW'(e_t_q);
    wsat = nmu_pkg::sat_q(diff);
  end

  always_ff @(posedge clk_i) begin
    if (en_c && req_valid_i) begin
      c_q <= req_i;
    end
    if (en_d && c_valid_q) begin
      d_p_q    <= p2;
      d_lg_q   <= c_q.lg;
      d_w_q    <= c_q.w;
      d_flag_q <= c_q.vflag;
    end
    if (en_e && d_valid_q) begin
      e_t_q    <= nmu_pkg::round_q(sum);
      e_w_q    <= d_w_q;
      e_flag_q <= d_flag_q;
    end
    if (en_o && e_valid_q) begin
      o_w_q    <= wsat.value;
      o_flag_q <= e_flag_q || wsat.flag;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign weight_out_o = o_w_q;
  assign saturated_o  = o_flag_q;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the Nesterov momentum update block.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned     IdxW            = nmu_pkg::IdxW;
  localparam int unsigned     DataW           = nmu_pkg::DataW;
  localparam int unsigned     CoefW           = nmu_pkg::CoefW;
  localparam logic [15:0]     LrReset         = nmu_pkg::LrReset;
  localparam logic [15:0]     MomReset        = nmu_pkg::MomReset;
  localparam logic            RegLearningRate = nmu_pkg::RegLearningRate;
  localparam logic            RegMomentum     = nmu_pkg::RegMomentum;

  localparam int unsigned VelDepth   = nmu_pkg::DefVelDepth;
  localparam int unsigned DirRows    = 24;
  localparam int unsigned Phases     = 6;
  localparam int unsigned PhaseBeats = 255;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned Latency    = 8;

  // One expected update result.
  typedef struct packed {
    logic [DataW-1:0] weight;
    logic             sat;
  } upd_result_t;

  // One directed stimulus row; exp_w and exp_sat are used only when chk is set.
  typedef struct packed {
    logic [CoefW-1:0] lr;
    logic [CoefW-1:0] beta;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] w;
    logic [DataW-1:0] g;
    logic             chk;
    logic [DataW-1:0] exp_w;
    logic             exp_sat;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni          = 1'b0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic [IdxW-1:0]         element_index_i = '0;
  logic signed [DataW-1:0] weight_in_i     = '0;
  logic signed [DataW-1:0] grad_in_i       = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic signed [DataW-1:0] weight_out_o;
  logic                    saturated_o;
  logic                    psel            = 1'b0;
  logic                    penable         = 1'b0;
  logic                    pwrite          = 1'b0;
  logic [2:0]              paddr           = '0;
  logic [31:0]             pwdata          = '0;
  logic [31:0]             prdata;
  logic                    pready;

  nesterov_momentum_update u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_index_i(element_index_i),
    .weight_in_i    (weight_in_i),
    .grad_in_i      (grad_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .weight_out_o   (weight_out_o),
    .saturated_o    (saturated_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Shadow copy of the block's state and configuration.
  int               velocity_shadow [VelDepth];
  logic [CoefW-1:0] lr_q   = LrReset;
  logic [CoefW-1:0] beta_q = MomReset;

  upd_result_t pending_updates [$];

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  bit          hold_armed  = 1'b0;
  bit          hold_done   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned mismatches  = 0;
  int unsigned beats_sent  = 0;
  int unsigned results_ok  = 0;
  int unsigned results_sat = 0;
  int unsigned cfg_writes  = 0;
  logic [IdxW-1:0] last_idx = '0;

  // Directed rows: fresh entries and extremes, repeats, saturation, zero coefficients.
  dir_row_t dir_rows [DirRows] = '{
    '{LrReset, MomReset, 12'd0,    32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
    '{LrReset, MomReset, 12'd4095, 32'h7FFFFFFF, 32'h00000000, 1'b1, 32'h7FFFFFFF, 1'b0},
    '{LrReset, MomReset, 12'd1,    32'h80000000, 32'h00000000, 1'b1, 32'h80000000, 1'b0},
    '{LrReset, MomReset, 12'd2,    32'h80000000, 32'h7FFFFFFF, 1'b1, 32'h80000000, 1'b1},
    '{LrReset, MomReset, 12'd3,    32'h7FFFFFFF, 32'h80000000, 1'b1, 32'h7FFFFFFF, 1'b1},
    '{LrReset, MomReset, 12'd5,    32'h00010000, 32'h00010000, 1'b0, 32'h0, 1'b0},
    '{LrReset, MomReset, 12'd5,    32'h00010000, 32'h00010000, 1'b0, 32'h0, 1'b0},
    '{LrReset, MomReset, 12'd5,    32'h00020000, 32'hFFFF0000, 1'b0, 32'h0, 1'b0},
    '{LrReset, MomReset, 12'd6,    32'hFFFF8000, 32'h00008000, 1'b0, 32'h0, 1'b0},
    '{LrReset, MomReset, 12'd5,    32'h00010000, 32'h00010000, 1'b0, 32'h0, 1'b0},
    '{LrReset, MomReset, 12'd4095, 32'h00000000, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
    '{LrReset, MomReset, 12'd4095, 32'h00000000, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
    '{LrReset, MomReset, 12'd0,    32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
    '{LrReset, MomReset, 12'd0,    32'h00000001, 32'h00000001, 1'b0, 32'h0, 1'b0},
    '{LrReset, MomReset, 12'd7,    32'h12345678, 32'hFEDCBA98, 1'b0, 32'h0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 12'd10,  32'h00000000, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 12'd10,  32'h00000000, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 12'd10,  32'h00000000, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 12'd11,  32'h00000000, 32'h80000000, 1'b0, 32'h0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 12'd11,  32'h00000000, 32'h80000000, 1'b0, 32'h0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 12'd11,  32'h7FFFFFFF, 32'h80000000, 1'b0, 32'h0, 1'b0},
    '{16'h0000, 16'h0000, 12'd12,  32'h5A5A5A5A, 32'h7FFFFFFF, 1'b1, 32'h5A5A5A5A, 1'b0},
    '{16'h0000, 16'h0000, 12'd10,  32'hA5A5A5A5, 32'h80000000, 1'b1, 32'hA5A5A5A5, 1'b0},
    '{16'h0000, 16'h0000, 12'd4095, 32'h80000000, 32'h7FFFFFFF, 1'b1, 32'h80000000, 1'b0}
  };

  // Per-phase coefficients, idling and stalling; phase 3 draws its coefficients at random.
  logic [CoefW-1:0] phase_lr   [Phases] = '{LrReset,  16'hFFFF, 16'h0000, 16'h0, 16'h0000, 16'hFFFF};
  logic [CoefW-1:0] phase_beta [Phases] = '{MomReset, 16'hFFFF, 16'h0000, 16'h0, 16'hFFFF, 16'h0000};
  int unsigned      phase_idle  [Phases] = '{0, 63, 0, 37, 0, 37};
  int unsigned      phase_stall [Phases] = '{0, 0, 63, 37, 0, 37};

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far above the slowest correct run, clearing pass included.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Round a Q18.32 sum to Q18.16, half up.
  function automatic longint round_half_up(input longint s);
    return (s + 64'sd32768) >>> 16;
  endfunction

  // Clip to the signed 32-bit range.
  function automatic longint clip_s32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Velocity update and look-ahead weight step; updates the shadow velocity.
  function automatic upd_result_t predict_update(input logic [IdxW-1:0] idx,
                                                 input logic signed [DataW-1:0] w,
                                                 input logic signed [DataW-1:0] g);
    longint      lr_l;
    longint      beta_l;
    longint      lg;
    longint      v_old;
    longint      acc;
    longint      vn;
    longint      wn;
    bit          clipped;
    upd_result_t res;
    lr_l    = lr_q;
    beta_l  = beta_q;
    v_old   = (idx < VelDepth) ? longint'(velocity_shadow[idx]) : 64'sd0;
    lg      = lr_l * longint'(g);
    acc     = round_half_up(beta_l * v_old + lg);
    vn      = clip_s32(acc);
    clipped = (vn != acc);
    if (idx < VelDepth) velocity_shadow[idx] = int'(vn);
    acc     = longint'(w) - round_half_up(beta_l * vn + lg);
    wn      = clip_s32(acc);
    clipped = clipped | (wn != acc);
    res.weight = wn[DataW-1:0];
    res.sat    = clipped;
    return res;
  endfunction

  // Random word: extremes, small magnitudes, or anything.
  function automatic logic [DataW-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(3))
        0: return 32'h7FFFFFFF;
        1: return 32'h80000000;
        2: return 32'h00000000;
        default: return 32'hFFFFFFFF;
      endcase
    end
    if (pick < 60) return 32'($urandom_range(2097151)) - 32'd1048576;
    return $urandom;
  endfunction

  // Write one configuration register over the APB port, then idle the bus before returning.
  task automatic cfg_write(input logic reg_sel, input logic [CoefW-1:0] value);
    logic [31:0] data;
    data = {16'($urandom), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == RegLearningRate) lr_q = data[CoefW-1:0];
    else beta_q = data[CoefW-1:0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // Offer one input beat after a random gap and hold it until accepted.
  task automatic offer_beat(input logic [IdxW-1:0] idx, input logic [DataW-1:0] w,
                            input logic [DataW-1:0] g, input logic chk,
                            input logic [DataW-1:0] exp_w, input logic exp_sat);
    upd_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_index_i <= idx;
    weight_in_i     <= w;
    grad_in_i       <= g;
    do @(posedge clk_i); while (in_stall_o);
    res = predict_update(idx, w, g);
    if (chk) begin
      res.weight = exp_w;
      res.sat    = exp_sat;
    end
    pending_updates.push_back(res);
    last_idx = idx;
    beats_sent++;
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic drain_updates();
    in_valid_i <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  // Output stall: random per phase, plus one long hold-off once armed.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    upd_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_updates.size() == 0) begin
        $error("result beat with no expectation: weight_out %0d, saturated %0b",
               weight_out_o, saturated_o);
        mismatches++;
      end else begin
        want = pending_updates.pop_front();
        if (weight_out_o !== want.weight) begin
          $error("weight_out: expected %0d, got %0d", $signed(want.weight), weight_out_o);
          mismatches++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          mismatches++;
        end
        results_ok++;
        if (want.sat) results_sat++;
      end
    end
  end

  // Stimulus: reset, directed rows, then randomized phases.
  initial begin
    logic [IdxW-1:0]  idx;
    logic [CoefW-1:0] lr_v;
    logic [CoefW-1:0] beta_v;
    int unsigned      pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; coefficients change only with the block drained.
    for (int unsigned row = 0; row < DirRows; row++) begin
      if (dir_rows[row].lr != lr_q || dir_rows[row].beta != beta_q) begin
        drain_updates();
        cfg_write(RegLearningRate, dir_rows[row].lr);
        cfg_write(RegMomentum, dir_rows[row].beta);
      end
      offer_beat(dir_rows[row].idx, dir_rows[row].w, dir_rows[row].g,
                 dir_rows[row].chk, dir_rows[row].exp_w, dir_rows[row].exp_sat);
    end

    // Random phases; indices favor repeats so that back-to-back updates hit one entry.
    for (int unsigned ph = 0; ph < Phases; ph++) begin
      drain_updates();
      lr_v   = (ph == 3) ? 16'($urandom) : phase_lr[ph];
      beta_v = (ph == 3) ? 16'($urandom) : phase_beta[ph];
      cfg_write(RegLearningRate, lr_v);
      cfg_write(RegMomentum, beta_v);
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 0) hold_armed = 1'b1;
      for (int unsigned k = 0; k < PhaseBeats; k++) begin
        pick = $urandom_range(99);
        if (pick < 30) idx = last_idx;
        else if (pick < 50) idx = 12'($urandom_range(7));
        else idx = 12'($urandom);
        offer_beat(idx, rand_word(), rand_word(), 1'b0, '0, 1'b0);
      end
    end
    drain_updates();

    $display("Sent %0d beats under %0d register writes, including zero and full-scale",
             beats_sent, cfg_writes);
    $display("coefficients; %0d results checked, %0d of them clipped.",
             results_ok, results_sat);
    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/nmu_pkg.sv
rtl/nmu_vel_ram.sv
rtl/nmu_vel_unit.sv
rtl/nmu_wt_unit.sv
rtl/nesterov_momentum_update.sv
tb/sv/tb_top.sv
